/* hw/rtl/assert_macros.svh */
// Assertion macros used by the parser core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

/* hw/rtl/hrhp_pkg.sv */
// Package: constants, types and character helpers of the request head parser.
`timescale 1ns / 1ps
`default_nettype none
package hrhp_pkg;
   localparam int MIN_BUFFER = 8;
   localparam int POS_WIDTH = 16;
   localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

   typedef enum logic [16:0] {
      PH_BEGIN     = 17'h00001,
      PH_METHOD    = 17'h00002,
      PH_METH_SP   = 17'h00004,
      PH_PRE_URI   = 17'h00008,
      PH_URI       = 17'h00010,
      PH_VER_NAME  = 17'h00020,
      PH_VER_MAJ0  = 17'h00040,
      PH_VER_MAJOR = 17'h00080,
      PH_VER_DOT   = 17'h00100,
      PH_VER_MINOR = 17'h00200,
      PH_VER_END   = 17'h00400,
      PH_LINE_END  = 17'h00800,
      PH_BLANK_CR  = 17'h01000,
      PH_HNAME     = 17'h02000,
      PH_HCOLON    = 17'h04000,
      PH_HVALUE    = 17'h08000,
      PH_HCR       = 17'h10000
   } phase_type;

   localparam logic [3:0] ST_OK = 4'd0;
   localparam logic [3:0] ST_SHORT = 4'd1;
   localparam logic [3:0] ST_METHOD = 4'd2;
   localparam logic [3:0] ST_URI = 4'd3;
   localparam logic [3:0] ST_VERSION = 4'd4;
   localparam logic [3:0] ST_UNSUPP = 4'd5;
   localparam logic [3:0] ST_CRLF = 4'd6;
   localparam logic [3:0] ST_HEADER = 4'd7;
   localparam logic [3:0] ST_CHAR = 4'd8;
   localparam logic [3:0] ST_LENGTH = 4'd9;
   localparam logic [3:0] ST_END = 4'd10;
   localparam logic [3:0] ST_TOO_LARGE = 4'd11;
   localparam logic [3:0] ST_INCOMPLETE = 4'd12;

   localparam logic [2:0] M_NONE = 3'd0;
   localparam logic [2:0] M_GET = 3'd1;
   localparam logic [2:0] M_HEAD = 3'd2;
   localparam logic [2:0] M_POST = 3'd3;
   localparam logic [2:0] M_OPTIONS = 3'd4;

   // Header names and values matched without regard to case.
   localparam logic [8*14-1:0] KEY_LEN_TEXT = "content-length";
   localparam logic [8*10-1:0] KEY_CON_TEXT = "connection";
   localparam logic [8*10-1:0] KEY_KEEP_TEXT = "keep-alive";
   localparam logic [8*5-1:0] KEY_CLOSE_TEXT = "close";

   // Parser state carried from byte to byte.
   typedef struct packed {
      phase_type              phase;
      logic [3:0]             idx;
      logic [POS_WIDTH-1:0]   pos;
      logic [2:0]             meth;
      logic [7:0]             major;
      logic [7:0]             minor;
      logic [POS_WIDTH-1:0]   uri_start;
      logic [POS_WIDTH-1:0]   uri_count;
      logic [1:0]             name_flags;
      logic [2:0]             value_flags;
      logic [31:0]            length;
      logic [1:0]             alive;
      logic                   draining;
   } pstate_type;

   // One finished result.
   typedef struct packed {
      logic [3:0]  status;
      logic [2:0]  method;
      logic [7:0]  major;
      logic [7:0]  minor;
      logic [15:0] uri_offset;
      logic [15:0] uri_bytes;
      logic [31:0] body_length;
      logic        persist;
      logic [15:0] body_offset;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'd48 && c <= 8'd57;
   endfunction

   function automatic logic is_header(input logic [7:0] c);
      return is_digit(c) || (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122)
         || c == 8'd45 || c == 8'd95;
   endfunction

   function automatic logic is_uri(input logic [7:0] c);
      return (c >= 8'd35 && c <= 8'd38) || (c >= 8'd43 && c <= 8'd59) || c == 8'd61
         || (c >= 8'd63 && c <= 8'd90) || c == 8'd95 || (c >= 8'd97 && c <= 8'd122);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
   endfunction

   // Remaining method letters after the first.
   function automatic logic [7:0] method_char(input logic [2:0] m, input logic [3:0] i);
      logic [7:0] r;
      r = 8'd0;
      case (m)
         M_GET: case (i) 4'd0: r = "E"; 4'd1: r = "T"; default: r = 8'd0; endcase
         M_HEAD: case (i) 4'd0: r = "E"; 4'd1: r = "A"; 4'd2: r = "D";
            default: r = 8'd0; endcase
         M_POST: case (i) 4'd0: r = "O"; 4'd1: r = "S"; 4'd2: r = "T";
            default: r = 8'd0; endcase
         M_OPTIONS: case (i) 4'd0: r = "P"; 4'd1: r = "T"; 4'd2: r = "I";
            4'd3: r = "O"; 4'd4: r = "N"; 4'd5: r = "S"; default: r = 8'd0; endcase
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] method_len(input logic [2:0] m);
      logic [3:0] r;
      case (m)
         M_GET: r = 4'd2;
         M_HEAD: r = 4'd3;
         M_POST: r = 4'd3;
         M_OPTIONS: r = 4'd6;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] key_char(input logic [1:0] k, input logic [3:0] i);
      // k: 0 content-length, 1 connection, 2 keep-alive, 3 close
      logic [7:0] r;
      r = 8'd0;
      case (k)
         2'd0: if (i < 4'd14) r = KEY_LEN_TEXT[8*(13-i) +: 8];
         2'd1: if (i < 4'd10) r = KEY_CON_TEXT[8*(9-i) +: 8];
         2'd2: if (i < 4'd10) r = KEY_KEEP_TEXT[8*(9-i) +: 8];
         default: if (i < 4'd5) r = KEY_CLOSE_TEXT[8*(4-i) +: 8];
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/hrhp_step.sv */
// Combinational next-state and result logic for one request byte.
`timescale 1ns / 1ps
`default_nettype none
module hrhp_step (
   input  hrhp_pkg::pstate_type  cur,
   input  logic [7:0]            c,
   input  logic [15:0]           left,
   output hrhp_pkg::pstate_type  nxt,
   output logic                  emit,
   output hrhp_pkg::result_type  res
);
   localparam logic [hrhp_pkg::POS_WIDTH-1:0] POS_ZERO = '0;
   localparam logic [hrhp_pkg::POS_WIDTH-1:0] POS_ONE = 1;

   hrhp_pkg::pstate_type s;
   hrhp_pkg::pstate_type rst_state;
   logic                 st_v;
   logic [3:0]           st;
   logic                 last;
   logic [15:0]          remaining;
   logic [35:0]          len_mul;
   logic [11:0]          d8;
   logic [7:0]           dig;
   logic [3:0]           mlen;
   logic                 alive_out;
   logic                 name_hit0;
   logic                 name_hit1;
   logic                 val_hit0;
   logic                 val_hit1;
   logic [3:0]           idx_bump;

   always_comb begin
      rst_state = '0;
      rst_state.phase = hrhp_pkg::PH_BEGIN;
      rst_state.name_flags = 2'b11;
      rst_state.value_flags = 3'b111;
      rst_state.alive = 2'b01;

      last = left <= 16'd1;
      remaining = (left == 16'd0) ? 16'd0 : left - 16'd1;
      dig = c - 8'd48;
      mlen = hrhp_pkg::method_len(cur.meth);
      idx_bump = (cur.idx < 4'd15) ? cur.idx + 4'd1 : cur.idx;
      name_hit0 = hrhp_pkg::to_lower(c) == hrhp_pkg::key_char(2'd0, cur.idx)
         && cur.idx < 4'd14;
      name_hit1 = hrhp_pkg::to_lower(c) == hrhp_pkg::key_char(2'd1, cur.idx)
         && cur.idx < 4'd10;
      val_hit0 = hrhp_pkg::to_lower(c) == hrhp_pkg::key_char(2'd2, cur.idx)
         && cur.idx < 4'd10;
      val_hit1 = hrhp_pkg::to_lower(c) == hrhp_pkg::key_char(2'd3, cur.idx)
         && cur.idx < 4'd5;
      len_mul = {4'd0, cur.length} * 36'd10 + {28'd0, dig};
      d8 = {4'd0, (cur.phase == hrhp_pkg::PH_VER_MAJOR) ? cur.major : cur.minor}
         * 12'd10 + {4'd0, dig};

      s = cur;
      st_v = 1'b0;
      st = hrhp_pkg::ST_OK;
      case (cur.phase)
         hrhp_pkg::PH_BEGIN: begin
            if (c == " ") begin
            end else if (c == "G" || c == "H" || c == "P" || c == "O") begin
               s.meth = (c == "G") ? hrhp_pkg::M_GET : (c == "H") ? hrhp_pkg::M_HEAD :
                  (c == "P") ? hrhp_pkg::M_POST : hrhp_pkg::M_OPTIONS;
               s.idx = 4'd0;
               s.phase = hrhp_pkg::PH_METHOD;
            end else begin
               st_v = 1'b1; st = hrhp_pkg::ST_METHOD;
            end
         end
         hrhp_pkg::PH_METHOD: begin
            if (cur.idx >= mlen || c != hrhp_pkg::method_char(cur.meth, cur.idx)) begin
               st_v = 1'b1; st = hrhp_pkg::ST_METHOD;
            end else begin
               s.idx = cur.idx + 4'd1;
               if (cur.idx + 4'd1 == mlen) s.phase = hrhp_pkg::PH_METH_SP;
            end
         end
         hrhp_pkg::PH_METH_SP: begin
            if (c != " ") begin
               st_v = 1'b1; st = hrhp_pkg::ST_METHOD;
            end else s.phase = hrhp_pkg::PH_PRE_URI;
         end
         hrhp_pkg::PH_PRE_URI: begin
            if (c == " ") begin
            end else if (!hrhp_pkg::is_uri(c)) begin
               st_v = 1'b1; st = hrhp_pkg::ST_URI;
            end else begin
               s.uri_start = cur.pos;
               s.uri_count = POS_ONE;
               s.phase = hrhp_pkg::PH_URI;
            end
         end
         hrhp_pkg::PH_URI: begin
            if (hrhp_pkg::is_uri(c)) begin
               if (cur.uri_count != hrhp_pkg::POS_MAX) s.uri_count = cur.uri_count + POS_ONE;
            end else if (c != " ") begin
               st_v = 1'b1; st = hrhp_pkg::ST_URI;
            end else begin
               s.idx = 4'd0;
               s.phase = hrhp_pkg::PH_VER_NAME;
            end
         end
         hrhp_pkg::PH_VER_NAME: begin
            if (cur.idx >= 4'd5 || c != ((cur.idx == 4'd4) ? 8'h2F :
                (cur.idx == 4'd0) ? 8'h48 : (cur.idx == 4'd3) ? 8'h50 : 8'h54)) begin
               st_v = 1'b1; st = hrhp_pkg::ST_VERSION;
            end else begin
               s.idx = cur.idx + 4'd1;
               if (cur.idx == 4'd4) s.phase = hrhp_pkg::PH_VER_MAJ0;
            end
         end
         hrhp_pkg::PH_VER_MAJ0: begin
            if (!hrhp_pkg::is_digit(c)) begin
               st_v = 1'b1; st = hrhp_pkg::ST_VERSION;
            end else begin
               s.major = dig;
               s.phase = hrhp_pkg::PH_VER_MAJOR;
            end
         end
         hrhp_pkg::PH_VER_MAJOR: begin
            if (hrhp_pkg::is_digit(c)) s.major = (d8 > 12'd255) ? 8'd255 : d8[7:0];
            else if (c != ".") begin
               st_v = 1'b1; st = hrhp_pkg::ST_VERSION;
            end else s.phase = hrhp_pkg::PH_VER_DOT;
         end
         hrhp_pkg::PH_VER_DOT, hrhp_pkg::PH_VER_MINOR: begin
            if (hrhp_pkg::is_digit(c)) begin
               s.minor = (cur.phase == hrhp_pkg::PH_VER_DOT) ? dig :
                  ((d8 > 12'd255) ? 8'd255 : d8[7:0]);
               s.phase = hrhp_pkg::PH_VER_MINOR;
            end else if (c != 8'h0D) begin
               st_v = 1'b1; st = hrhp_pkg::ST_VERSION;
            end else s.phase = hrhp_pkg::PH_VER_END;
         end
         hrhp_pkg::PH_VER_END: begin
            if (cur.major != 8'd1 && cur.minor != 8'd0 && cur.minor != 8'd1) begin
               st_v = 1'b1; st = hrhp_pkg::ST_UNSUPP;
            end else if (c != 8'h0A) begin
               st_v = 1'b1; st = hrhp_pkg::ST_VERSION;
            end else s.phase = hrhp_pkg::PH_LINE_END;
         end
         hrhp_pkg::PH_LINE_END: begin
            if (c == 8'h0D) s.phase = hrhp_pkg::PH_BLANK_CR;
            else if (!hrhp_pkg::is_header(c)) begin
               st_v = 1'b1; st = hrhp_pkg::ST_HEADER;
            end else begin
               // first name byte is always compared at index zero
               s.name_flags = {hrhp_pkg::to_lower(c) == "c", hrhp_pkg::to_lower(c) == "c"};
               s.idx = 4'd1;
               s.phase = hrhp_pkg::PH_HNAME;
            end
         end
         hrhp_pkg::PH_BLANK_CR: begin
            st_v = 1'b1;
            st = (c == 8'h0A) ? hrhp_pkg::ST_OK : hrhp_pkg::ST_CRLF;
         end
         hrhp_pkg::PH_HNAME: begin
            if (hrhp_pkg::is_header(c)) begin
               s.name_flags = cur.name_flags & {name_hit1, name_hit0};
               s.idx = idx_bump;
            end else if (c != ":") begin
               st_v = 1'b1; st = hrhp_pkg::ST_CHAR;
            end else begin
               s.name_flags = cur.name_flags & {cur.idx == 4'd10, cur.idx == 4'd14};
               s.phase = hrhp_pkg::PH_HCOLON;
            end
         end
         hrhp_pkg::PH_HCOLON, hrhp_pkg::PH_HVALUE: begin
            if (cur.phase == hrhp_pkg::PH_HCOLON && c == " ") begin
            end else if (hrhp_pkg::is_uri(c)) begin
               // first value byte restarts the value match at index zero
               if (cur.phase == hrhp_pkg::PH_HCOLON) begin
                  s.value_flags = {hrhp_pkg::is_digit(c), hrhp_pkg::to_lower(c) == "c",
                     hrhp_pkg::to_lower(c) == "k"};
                  s.idx = 4'd1;
               end else begin
                  s.value_flags = cur.value_flags & {hrhp_pkg::is_digit(c), val_hit1, val_hit0};
                  s.idx = idx_bump;
               end
               if (hrhp_pkg::is_digit(c) && cur.name_flags[0])
                  s.length = (len_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF : len_mul[31:0];
               s.phase = hrhp_pkg::PH_HVALUE;
            end else if (cur.phase == hrhp_pkg::PH_HCOLON) begin
               st_v = 1'b1; st = hrhp_pkg::ST_CHAR;
            end else if (c != 8'h0D) begin
               st_v = 1'b1; st = hrhp_pkg::ST_END;
            end else begin
               s.value_flags = cur.value_flags & {1'b1, cur.idx == 4'd5, cur.idx == 4'd10};
               s.phase = hrhp_pkg::PH_HCR;
            end
         end
         hrhp_pkg::PH_HCR: begin
            if (cur.name_flags[0] && !cur.value_flags[2]) begin
               s.length = 32'd0;
               st_v = 1'b1; st = hrhp_pkg::ST_LENGTH;
            end else begin
               if (cur.name_flags[1]) begin
                  s.alive[1] = 1'b1;
                  if (cur.value_flags[0]) s.alive[0] = 1'b1;
                  else if (cur.value_flags[1]) s.alive[0] = 1'b0;
                  else begin
                     st_v = 1'b1; st = hrhp_pkg::ST_HEADER;
                  end
               end
               if (!st_v) begin
                  if (c != 8'h0A) begin
                     st_v = 1'b1; st = hrhp_pkg::ST_CRLF;
                  end else s.phase = hrhp_pkg::PH_LINE_END;
               end
            end
         end
         default: begin
            st_v = 1'b1; st = hrhp_pkg::ST_END;
         end
      endcase

      // the short-buffer check overrides parsing of the first byte
      if (cur.phase == hrhp_pkg::PH_BEGIN && cur.pos == POS_ZERO
          && left < 16'(hrhp_pkg::MIN_BUFFER)) begin
         s = cur;
         st_v = 1'b1;
         st = hrhp_pkg::ST_SHORT;
      end else begin
         if (cur.pos != hrhp_pkg::POS_MAX) s.pos = cur.pos + POS_ONE;
         if (!st_v && last) begin
            st_v = 1'b1; st = hrhp_pkg::ST_INCOMPLETE;
         end
      end
      if (st_v && s.length > {16'd0, remaining}) st = hrhp_pkg::ST_TOO_LARGE;

      alive_out = s.alive[1] ? s.alive[0] : (s.major != 8'd0);
      res.status = st;
      res.method = (s.phase == hrhp_pkg::PH_BEGIN || s.phase == hrhp_pkg::PH_METHOD) ?
         hrhp_pkg::M_NONE : s.meth;
      res.major = s.major;
      res.minor = s.minor;
      res.uri_offset = 16'(s.uri_start);
      res.uri_bytes = 16'(s.uri_count);
      res.body_length = s.length;
      res.persist = alive_out;
      res.body_offset = (st == hrhp_pkg::ST_SHORT) ? 16'd0 : 16'(s.pos);

      emit = st_v && !cur.draining;
      if (cur.draining) nxt = last ? rst_state : cur;
      else if (st_v) begin
         if (last) nxt = rst_state;
         else begin
            nxt = s;
            nxt.draining = 1'b1;
         end
      end else nxt = s;
   end
endmodule
`default_nettype wire

/* hw/rtl/http_request_head_parser_core.sv */
// Top level of the HTTP request head parser: byte handshake and result register.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_ready  req_data_byte, req_bytes_left
//   rsp_     out        rsp_valid / rsp_ready  status, method, version, uri, body fields
//
// A request is parsed in the cycle it is accepted; its result, if any, is
// registered and shown the next cycle, so one byte per cycle is sustained.
// The only stall is a pending result: a new request is taken while the
// result register is empty or is being drained in the same cycle.
// Reset (synchronous, active high) puts the parser at the start of a buffer.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module http_request_head_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_bytes_left,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_status,
   output logic [2:0]  rsp_method,
   output logic [7:0]  rsp_version_major,
   output logic [7:0]  rsp_version_minor,
   output logic [15:0] rsp_uri_offset,
   output logic [15:0] rsp_uri_bytes,
   output logic [31:0] rsp_body_length,
   output logic        rsp_persist,
   output logic [15:0] rsp_body_offset
);
   hrhp_pkg::pstate_type state_ff;
   hrhp_pkg::pstate_type state_in;
   hrhp_pkg::result_type res_ff;
   hrhp_pkg::result_type res_in;
   hrhp_pkg::pstate_type rst_state;
   logic                 emit;
   logic                 valid_ff;
   logic                 valid_in;
   logic                 take;

   hrhp_step u_step (
      .cur  (state_ff),
      .c    (req_data_byte),
      .left (req_bytes_left),
      .nxt  (state_in),
      .emit (emit),
      .res  (res_in)
   );

   // accept while the result slot is free or emptying this cycle
   assign req_ready = !valid_ff || rsp_ready;
   assign take = req_valid && req_ready;
   assign valid_in = take ? emit : (valid_ff && !rsp_ready);

   always_comb begin
      rst_state = '0;
      rst_state.phase = hrhp_pkg::PH_BEGIN;
      rst_state.name_flags = 2'b11;
      rst_state.value_flags = 3'b111;
      rst_state.alive = 2'b01;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rst_state;
         valid_ff <= 1'b0;
      end else begin
         if (take) state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // hold payload until taken
   always_ff @(posedge clock) begin
      if (take && emit) res_ff <= res_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_status = res_ff.status;
   assign rsp_method = res_ff.method;
   assign rsp_version_major = res_ff.major;
   assign rsp_version_minor = res_ff.minor;
   assign rsp_uri_offset = res_ff.uri_offset;
   assign rsp_uri_bytes = res_ff.uri_bytes;
   assign rsp_body_length = res_ff.body_length;
   assign rsp_persist = res_ff.persist;
   assign rsp_body_offset = res_ff.body_offset;

   `ASSERT_IMPLIES(a_no_take_when_full, clock, reset, valid_ff && !rsp_ready, !req_ready)
   `ASSERT_NEXT(a_emit_drains, clock, reset, take && emit && req_bytes_left > 16'd1,
      state_ff.draining)
   `ASSERT_NEXT(a_last_resets, clock, reset, take && req_bytes_left <= 16'd1,
      state_ff.phase == hrhp_pkg::PH_BEGIN && !state_ff.draining)
   `ASSERT_IMPLIES(a_drain_silent, clock, reset, state_ff.draining, !emit)
endmodule
`default_nettype wire

/* test/tb_http_request_head_parser_core.sv */
// Testbench for http_request_head_parser_core: directed and random request heads vs. a predictor.
`timescale 1ns / 1ps
module tb_http_request_head_parser_core;
   localparam int NO_RESULT = -1;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic [15:0] req_bytes_left;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_status;
   logic [2:0]  rsp_method;
   logic [7:0]  rsp_version_major;
   logic [7:0]  rsp_version_minor;
   logic [15:0] rsp_uri_offset;
   logic [15:0] rsp_uri_bytes;
   logic [31:0] rsp_body_length;
   logic        rsp_persist;
   logic [15:0] rsp_body_offset;

   http_request_head_parser_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_bytes_left(req_bytes_left),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_method(rsp_method),
      .rsp_version_major(rsp_version_major), .rsp_version_minor(rsp_version_minor),
      .rsp_uri_offset(rsp_uri_offset), .rsp_uri_bytes(rsp_uri_bytes),
      .rsp_body_length(rsp_body_length), .rsp_persist(rsp_persist),
      .rsp_body_offset(rsp_body_offset)
   );

   // Shadow copy of the parser state.
   hrhp_pkg::phase_type ph;
   logic [3:0]  midx;
   logic [15:0] bpos;
   logic [2:0]  meth;
   logic [7:0]  maj;
   logic [7:0]  mnr;
   logic [15:0] ustart;
   logic [15:0] ucount;
   logic [1:0]  nflags;
   logic [2:0]  vflags;
   logic [31:0] clen;
   logic [1:0]  alive;
   logic        drain;

   hrhp_pkg::result_type pending_heads[$];
   int          errors = 0;
   int          bytes_sent = 0;
   int          last_status;

   string method_tail[5] = '{"", "ET", "EAD", "OST", "PTIONS"};
   string ver_text = "HTTP/";

   function automatic bit dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit hdr_char(logic [7:0] c);
      return dig(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z")
         || c == "-" || c == "_";
   endfunction

   function automatic bit uri_char(logic [7:0] c);
      return (c >= 35 && c <= 38) || (c >= 43 && c <= 59) || c == 61
         || (c >= 63 && c <= 90) || c == 95 || (c >= 97 && c <= 122);
   endfunction

   function automatic logic [7:0] lower(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic bit key_hit(string key, logic [3:0] i, logic [7:0] c);
      return i < key.len() && lower(c) == key[i];
   endfunction

   function automatic logic [7:0] add_digit(logic [7:0] v, logic [7:0] c);
      int r;
      r = v * 10 + (c - "0");
      return r > 255 ? 8'd255 : r[7:0];
   endfunction

   function void parser_clear();
      ph = hrhp_pkg::PH_BEGIN; midx = 0; bpos = 0; meth = hrhp_pkg::M_NONE; maj = 0; mnr = 0;
      ustart = 0; ucount = 0; nflags = 2'b11; vflags = 3'b111; clen = 0;
      alive = 2'b01; drain = 0;
   endfunction

   function void name_step(logic [7:0] c);
      if (!key_hit("content-length", midx, c)) nflags[0] = 0;
      if (!key_hit("connection", midx, c)) nflags[1] = 0;
      if (midx < 15) midx++;
   endfunction

   function void value_step(logic [7:0] c);
      longint unsigned v;
      if (!key_hit("keep-alive", midx, c)) vflags[0] = 0;
      if (!key_hit("close", midx, c)) vflags[1] = 0;
      if (!dig(c)) vflags[2] = 0;
      else if (nflags[0]) begin
         v = longint'(clen) * 10 + (c - "0");
         clen = v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
      end
      if (midx < 15) midx++;
   endfunction

   // Advance the shadow parser by one byte; return a status or NO_RESULT.
   function int parse_char(logic [7:0] c);
      int m;
      case (ph)
         hrhp_pkg::PH_BEGIN: begin
            if (c == " ") return NO_RESULT;
            if (c == "G") meth = hrhp_pkg::M_GET;
            else if (c == "H") meth = hrhp_pkg::M_HEAD;
            else if (c == "P") meth = hrhp_pkg::M_POST;
            else if (c == "O") meth = hrhp_pkg::M_OPTIONS;
            else return hrhp_pkg::ST_METHOD;
            midx = 0;
            ph = hrhp_pkg::PH_METHOD;
         end
         hrhp_pkg::PH_METHOD: begin
            m = meth > hrhp_pkg::M_OPTIONS ? 0 : meth;
            if (midx >= method_tail[m].len() || c != method_tail[m][midx])
               return hrhp_pkg::ST_METHOD;
            midx++;
            if (midx == method_tail[m].len()) ph = hrhp_pkg::PH_METH_SP;
         end
         hrhp_pkg::PH_METH_SP: begin
            if (c != " ") return hrhp_pkg::ST_METHOD;
            ph = hrhp_pkg::PH_PRE_URI;
         end
         hrhp_pkg::PH_PRE_URI: begin
            if (c == " ") return NO_RESULT;
            if (!uri_char(c)) return hrhp_pkg::ST_URI;
            ustart = bpos;
            ucount = 1;
            ph = hrhp_pkg::PH_URI;
         end
         hrhp_pkg::PH_URI: begin
            if (uri_char(c)) begin
               if (ucount != 16'hFFFF) ucount++;
               return NO_RESULT;
            end
            if (c != " ") return hrhp_pkg::ST_URI;
            midx = 0;
            ph = hrhp_pkg::PH_VER_NAME;
         end
         hrhp_pkg::PH_VER_NAME: begin
            if (midx >= 5 || c != ver_text[midx]) return hrhp_pkg::ST_VERSION;
            midx++;
            if (midx == 5) ph = hrhp_pkg::PH_VER_MAJ0;
         end
         hrhp_pkg::PH_VER_MAJ0: begin
            if (!dig(c)) return hrhp_pkg::ST_VERSION;
            maj = c - "0";
            ph = hrhp_pkg::PH_VER_MAJOR;
         end
         hrhp_pkg::PH_VER_MAJOR: begin
            if (dig(c)) begin
               maj = add_digit(maj, c);
               return NO_RESULT;
            end
            if (c != ".") return hrhp_pkg::ST_VERSION;
            ph = hrhp_pkg::PH_VER_DOT;
         end
         hrhp_pkg::PH_VER_DOT, hrhp_pkg::PH_VER_MINOR: begin
            if (dig(c)) begin
               mnr = (ph == hrhp_pkg::PH_VER_DOT) ? c - "0" : add_digit(mnr, c);
               ph = hrhp_pkg::PH_VER_MINOR;
               return NO_RESULT;
            end
            if (c != 8'd13) return hrhp_pkg::ST_VERSION;
            ph = hrhp_pkg::PH_VER_END;
         end
         hrhp_pkg::PH_VER_END: begin
            // version test is made on whatever byte follows CR
            if (maj != 1 && mnr != 0 && mnr != 1) return hrhp_pkg::ST_UNSUPP;
            if (c != 8'd10) return hrhp_pkg::ST_VERSION;
            ph = hrhp_pkg::PH_LINE_END;
         end
         hrhp_pkg::PH_LINE_END: begin
            if (c == 8'd13) begin
               ph = hrhp_pkg::PH_BLANK_CR;
               return NO_RESULT;
            end
            if (!hdr_char(c)) return hrhp_pkg::ST_HEADER;
            nflags = 2'b11;
            midx = 0;
            name_step(c);
            ph = hrhp_pkg::PH_HNAME;
         end
         hrhp_pkg::PH_BLANK_CR: return c == 8'd10 ? hrhp_pkg::ST_OK : hrhp_pkg::ST_CRLF;
         hrhp_pkg::PH_HNAME: begin
            if (hdr_char(c)) begin
               name_step(c);
               return NO_RESULT;
            end
            if (c != ":") return hrhp_pkg::ST_CHAR;
            if (midx != 14) nflags[0] = 0;
            if (midx != 10) nflags[1] = 0;
            ph = hrhp_pkg::PH_HCOLON;
         end
         hrhp_pkg::PH_HCOLON: begin
            if (c == " ") return NO_RESULT;
            if (!uri_char(c)) return hrhp_pkg::ST_CHAR;
            vflags = 3'b111;
            midx = 0;
            value_step(c);
            ph = hrhp_pkg::PH_HVALUE;
         end
         hrhp_pkg::PH_HVALUE: begin
            if (uri_char(c)) begin
               value_step(c);
               return NO_RESULT;
            end
            if (c != 8'd13) return hrhp_pkg::ST_END;
            if (midx != 10) vflags[0] = 0;
            if (midx != 5) vflags[1] = 0;
            ph = hrhp_pkg::PH_HCR;
         end
         hrhp_pkg::PH_HCR: begin
            // any non-digit in a length value voids it
            if (nflags[0] && !vflags[2]) begin
               clen = 0;
               return hrhp_pkg::ST_LENGTH;
            end
            if (nflags[1]) begin
               alive[1] = 1;
               if (vflags[0]) alive[0] = 1;
               else if (vflags[1]) alive[0] = 0;
               else return hrhp_pkg::ST_HEADER;
            end
            if (c != 8'd10) return hrhp_pkg::ST_CRLF;
            ph = hrhp_pkg::PH_LINE_END;
         end
         default: return hrhp_pkg::ST_END;
      endcase
      return NO_RESULT;
   endfunction

   // Account for one accepted request; queue the head result it produces, if any.
   function void note_request(logic [7:0] c, logic [15:0] left);
      bit          last;
      logic [15:0] remaining;
      int          st;
      hrhp_pkg::result_type r;
      last = left <= 1;
      remaining = left == 0 ? 16'd0 : left - 16'd1;
      if (drain) begin
         if (last) parser_clear();
         return;
      end
      if (ph == hrhp_pkg::PH_BEGIN && bpos == 0 && left < hrhp_pkg::MIN_BUFFER)
         st = hrhp_pkg::ST_SHORT;
      else begin
         st = parse_char(c);
         if (bpos != 16'hFFFF) bpos++;
         if (st == NO_RESULT && last) st = hrhp_pkg::ST_INCOMPLETE;
      end
      if (st == NO_RESULT) return;
      if (clen > remaining) st = hrhp_pkg::ST_TOO_LARGE;
      r.status = st[3:0];
      r.method = (ph >= hrhp_pkg::PH_METH_SP) ? meth : hrhp_pkg::M_NONE;
      r.major = maj;
      r.minor = mnr;
      r.uri_offset = ustart;
      r.uri_bytes = ucount;
      r.body_length = clen;
      r.persist = alive[1] ? alive[0] : (maj != 0);
      r.body_offset = (st == hrhp_pkg::ST_SHORT) ? 16'd0 : bpos;
      pending_heads.push_back(r);
      last_status = st;
      if (last) parser_clear();
      else drain = 1;
   endfunction

   // Clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Hold rsp_ready in runs of random length: mostly short stalls, a few long.
   int ready_hold = 0;
   always @(negedge clock) begin
      if (ready_hold > 0) ready_hold <= ready_hold - 1;
      else if ($urandom_range(0, 2) != 0) begin
         rsp_ready <= 1;
         ready_hold <= $urandom_range(0, 30);
      end else begin
         rsp_ready <= 0;
         ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 3);
      end
   end

   task automatic chk_field(string nm, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, e, a);
         errors++;
      end
   endtask

   // Compare each accepted head result with the oldest prediction.
   always @(posedge clock) begin
      hrhp_pkg::result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_heads.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d",
                     $time, rsp_status);
            errors++;
         end else begin
            e = pending_heads.pop_front();
            chk_field("status", e.status, rsp_status);
            chk_field("method", e.method, rsp_method);
            chk_field("version_major", e.major, rsp_version_major);
            chk_field("version_minor", e.minor, rsp_version_minor);
            chk_field("uri_offset", e.uri_offset, rsp_uri_offset);
            chk_field("uri_bytes", e.uri_bytes, rsp_uri_bytes);
            chk_field("body_length", e.body_length, rsp_body_length);
            chk_field("persist", e.persist, rsp_persist);
            chk_field("body_offset", e.body_offset, rsp_body_offset);
         end
      end
   end

   // Send one request after a random gap; predict on acceptance.
   task automatic send_request(logic [7:0] c, logic [15:0] left);
      int gap;
      gap = $urandom_range(0, 99);
      gap = gap < 75 ? 0 : gap < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_data_byte <= c;
      req_bytes_left <= left;
      do @(posedge clock); while (!req_ready);
      note_request(c, left);
      bytes_sent++;
   endtask

   // Stream a buffer; the final byte always marks the buffer end.
   task automatic send_buffer(ref logic [7:0] q[$], input int declared);
      int n;
      int left;
      n = q.size();
      for (int i = 0; i < n; i++) begin
         left = declared - i;
         if (i == n - 1) left = 1;
         else if (left < 2) left = 2;
         else if (left > 65535) left = 65535;
         send_request(q[i], left[15:0]);
      end
   endtask

   function automatic void put_text(ref logic [7:0] q[$], input string s, input bit mix);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (mix && $urandom_range(0, 1) && c >= "a" && c <= "z") c -= 8'd32;
         q.push_back(c);
      end
   endfunction

   function automatic logic [7:0] pick_uri();
      logic [7:0] c;
      do c = 8'($urandom_range(33, 127)); while (!uri_char(c));
      return c;
   endfunction

   // Build a mostly well-formed head with random content, then maybe damage it.
   function automatic void build_head(ref logic [7:0] q[$], output int declared);
      string names[4] = '{"GET", "HEAD", "POST", "OPTIONS"};
      int n;
      int k;
      q.delete();
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) q.push_back(" ");
      put_text(q, names[$urandom_range(0, 3)], 0);
      repeat ($urandom_range(1, 2)) q.push_back(" ");
      repeat ($urandom_range(1, 12)) q.push_back(pick_uri());
      put_text(q, " HTTP/", 0);
      if ($urandom_range(0, 3) != 0) q.push_back("1");
      else repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range("0", "9")));
      if ($urandom_range(0, 4) != 0) begin
         q.push_back(".");
         if ($urandom_range(0, 3) != 0) q.push_back(8'($urandom_range("0", "1")));
         else repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range("0", "9")));
      end
      put_text(q, "\015\012", 0);
      repeat ($urandom_range(0, 4)) begin
         k = $urandom_range(0, 2);
         if (k == 0) begin
            put_text(q, "content-length: ", 1);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
            repeat (n) q.push_back(8'($urandom_range("0", "9")));
         end else if (k == 1) begin
            put_text(q, "connection:", 1);
            put_text(q, $urandom_range(0, 1) ? "keep-alive" : "close", 1);
         end else begin
            repeat ($urandom_range(1, 8)) q.push_back($urandom_range(0, 1) ? "x" : "-");
            put_text(q, ": ", 0);
            repeat ($urandom_range(1, 8)) q.push_back(pick_uri());
         end
         put_text(q, "\015\012", 0);
      end
      put_text(q, "\015\012", 0);
      // damage a fraction of the heads: flip a byte, truncate
      if ($urandom_range(0, 3) == 0)
         q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) q = q[0:$urandom_range(0, q.size() - 1)];
      n = q.size();
      k = $urandom_range(0, 19);
      if (k == 0) begin
         declared = $urandom_range(1, hrhp_pkg::MIN_BUFFER - 1);
         if (n > declared) q = q[0:declared - 1];
      end else if (k < 6) declared = $urandom_range(n, 65535);
      else declared = n + $urandom_range(0, 300);
   endfunction

   typedef struct {
      string txt;
      int    declared;
      int    status;
   } head_case_type;

   // declared 0: buffer holds exactly the text; status NO_RESULT: predictor only
   head_case_type head_cases[19] = '{
      '{"GET / HTTP/1.1\015\012\015\012", 0, hrhp_pkg::ST_OK},
      '{"XYZ / HTTP/1.1\015\012\015\012", 0, hrhp_pkg::ST_METHOD},
      '{"GEX / HTTP/1.1\015\012\015\012", 0, hrhp_pkg::ST_METHOD},
      '{"HEAD /a HTTP/1.0\015\012Connection: close\015\012\015\012", 0, hrhp_pkg::ST_OK},
      '{"POST /x HTTP/1.1\015\012Content-Length: 1x\015\012\015\012", 0,
        hrhp_pkg::ST_LENGTH},
      '{"OPTIONS * HTTP/1.1\015\012\015\012", 0, hrhp_pkg::ST_URI},
      '{"GET /a HTTQ/1.1\015\012\015\012", 0, hrhp_pkg::ST_VERSION},
      '{"GET / HTTP/2.5\015\012\015\012", 0, hrhp_pkg::ST_UNSUPP},
      '{"GET / HTTP/1.1\015\012\015X", 0, hrhp_pkg::ST_CRLF},
      '{"GET / HTTP/1.1\015\012@\015\012", 0, hrhp_pkg::ST_HEADER},
      '{"GET / HTTP/1.1\015\012Host@x\015\012", 0, hrhp_pkg::ST_CHAR},
      '{"GET / HTTP/1.1\015\012Host: a b\015\012", 0, hrhp_pkg::ST_END},
      '{"GET / HTTP/1.1\015\012Content-Length: 99999\015\012\015\012", 0,
        hrhp_pkg::ST_TOO_LARGE},
      '{"GET / HT", 0, hrhp_pkg::ST_INCOMPLETE},
      '{"GETXY", 5, hrhp_pkg::ST_SHORT},
      '{"GET /\310 HTTP/1.1\015\012\015\012", 0, hrhp_pkg::ST_URI},
      '{"GET / HTTP/1.1\015\012Connection: maybe\015\012\015\012", 0, hrhp_pkg::ST_HEADER},
      '{"POST /u HTTP/1.1\015\012Content-Length: 12\015\012content-length: 3\015\012"
        , 0, NO_RESULT},
      '{"  OPTIONS /p?q=1 HTTP/255.255\015\012CONNECTION: Keep-Alive\015\012"
        , 65535, NO_RESULT}
   };

   initial begin
      logic [7:0] q[$];
      int declared;
      int heads;
      parser_clear();
      reset = 1;
      req_valid = 0;
      req_data_byte = 0;
      req_bytes_left = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed heads
      foreach (head_cases[i]) begin
         q.delete();
         put_text(q, head_cases[i].txt, 0);
         declared = head_cases[i].declared == 0 ? q.size() : head_cases[i].declared;
         last_status = NO_RESULT;
         send_buffer(q, declared);
         if (head_cases[i].status >= 0 && last_status != head_cases[i].status) begin
            $display("%0t: head case %0d status mismatch, expected %0d, actual %0d",
                     $time, i, head_cases[i].status, last_status);
            errors++;
         end
      end

      // random heads; once, hold the sender until all results are back
      heads = 0;
      while (bytes_sent < 1650 || heads < 60) begin
         build_head(q, declared);
         send_buffer(q, declared);
         heads++;
         if (heads == 15) begin
            @(negedge clock);
            req_valid <= 0;
            wait (pending_heads.size() == 0);
         end
      end

      @(negedge clock);
      req_valid <= 0;
      wait (pending_heads.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("http_request_head_parser_core verification clean");
      else $display("http_request_head_parser_core verification failed");
      $finish;
   end

   // Watchdog
   initial begin
      #50ms;
      $display("http_request_head_parser_core verification failed");
      $finish;
   end
endmodule
